// File: src/apci_pkg.sv
`default_nettype none

package apci_pkg;

	localparam int SeqW = 15;

	localparam logic [1:0] FUNC_RX     = 2'd0;
	localparam logic [1:0] FUNC_INTERR = 2'd1;
	localparam logic [1:0] FUNC_SEND_U = 2'd2;
	localparam logic [1:0] FUNC_SEND_S = 2'd3;

	localparam logic [7:0] U_STARTDT_CON = 8'h0B;
	localparam logic [7:0] U_STOPDT_CON  = 8'h23;
	localparam logic [7:0] U_TESTFR_ACT  = 8'h43;
	localparam logic [7:0] U_TESTFR_CON  = 8'h83;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SEQ_FAIL = 2'd1;
	localparam logic [1:0] ST_STOPPED  = 2'd2;

	localparam logic [1:0] TX_NONE = 2'd0;
	localparam logic [1:0] TX_S    = 2'd1;
	localparam logic [1:0] TX_U    = 2'd2;
	localparam logic [1:0] TX_I    = 2'd3;

	localparam logic [3:0] LEN_SU = 4'd4;
	localparam logic [3:0] LEN_I  = 4'd14;

	localparam logic [SeqW-1:0] ACK_WINDOW_RESET = 15'd8;
	localparam logic [SeqW-1:0] SEQ_MAX          = 15'h7FFF;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_RX_I,
		OP_RX_START,
		OP_RX_STOP,
		OP_RX_TESTACT,
		OP_RX_TESTCON,
		OP_INTERR,
		OP_SEND_U,
		OP_SEND_TESTACT,
		OP_SEND_S
	} op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] rx_control;
		logic [7:0]  rx_apdu_len;
		logic [15:0] interrogation_address;
		logic [7:0]  u_command;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  tx_kind;
		logic [3:0]  tx_apdu_len;
		logic [31:0] tx_control;
		logic [15:0] tx_common_address;
		logic        asdu_ready;
		logic [7:0]  asdu_size;
		logic        started;
		logic        test_pending;
	} out_t;

	typedef struct packed {
		op_t            op;
		logic [SeqW-1:0] ns;
		logic [7:0]     asdu_size;
		logic [15:0]    addr;
		logic [7:0]     octet;
	} item_t;

endpackage

`default_nettype wire

// File: src/apci_front.sv
`default_nettype none

module apci_front (
	input  wire apci_pkg::in_t   in_data,
	output apci_pkg::item_t      item
);

	logic [7:0] c0;

	assign c0 = in_data.rx_control[7:0];

	always_comb begin
		item.op       = apci_pkg::OP_NOP;
		item.ns       = in_data.rx_control[15:1];
		item.asdu_size = (in_data.rx_apdu_len >= 8'd4) ? (in_data.rx_apdu_len - 8'd4) : 8'd0;
		item.addr     = in_data.interrogation_address;
		item.octet    = in_data.u_command;
		case (in_data.func)
			apci_pkg::FUNC_RX: begin
				if (!c0[0]) begin
					item.op = apci_pkg::OP_RX_I;
				end else if (c0[1]) begin
					case (c0)
						apci_pkg::U_STARTDT_CON: item.op = apci_pkg::OP_RX_START;
						apci_pkg::U_STOPDT_CON:  item.op = apci_pkg::OP_RX_STOP;
						apci_pkg::U_TESTFR_ACT:  item.op = apci_pkg::OP_RX_TESTACT;
						apci_pkg::U_TESTFR_CON:  item.op = apci_pkg::OP_RX_TESTCON;
						default:                 item.op = apci_pkg::OP_NOP;
					endcase
				end
			end
			apci_pkg::FUNC_INTERR: item.op = apci_pkg::OP_INTERR;
			apci_pkg::FUNC_SEND_U: begin
				item.op = (in_data.u_command == apci_pkg::U_TESTFR_ACT) ?
					apci_pkg::OP_SEND_TESTACT : apci_pkg::OP_SEND_U;
			end
			apci_pkg::FUNC_SEND_S: item.op = apci_pkg::OP_SEND_S;
			default:               item.op = apci_pkg::OP_NOP;
		endcase
	end

endmodule

`default_nettype wire

// File: src/apci_queue.sv
`default_nettype none

module apci_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire apci_pkg::item_t push_data,
	output logic                 full,
	input  wire                  pop,
	output logic                 rd_valid,
	output apci_pkg::item_t      rd_data
);

	apci_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/apci_back.sv
`default_nettype none

module apci_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire [14:0]           cfg_wdata,
	input  wire                  rd_valid,
	input  wire apci_pkg::item_t rd_data,
	output logic                 pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output apci_pkg::out_t       out_data
);

	logic [apci_pkg::SeqW-1:0] ack_window_q;
	logic [apci_pkg::SeqW-1:0] rcv_cnt_q;
	logic [apci_pkg::SeqW-1:0] snd_cnt_q;
	logic [apci_pkg::SeqW-1:0] unack_q;
	logic                      started_q;
	logic                      test_q;
	logic                      out_valid_q;
	apci_pkg::out_t            out_q;

	logic [apci_pkg::SeqW-1:0] rcv_nxt;
	logic [apci_pkg::SeqW-1:0] snd_nxt;
	logic [apci_pkg::SeqW-1:0] unack_nxt;
	logic [apci_pkg::SeqW-1:0] unack_inc;
	logic                      started_nxt;
	logic                      test_nxt;
	apci_pkg::out_t            res;

	assign pop       = rd_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign unack_inc = (unack_q < apci_pkg::SEQ_MAX) ? (unack_q + 15'd1) : unack_q;

	always_comb begin
		rcv_nxt     = rcv_cnt_q;
		snd_nxt     = snd_cnt_q;
		unack_nxt   = unack_q;
		started_nxt = started_q;
		test_nxt    = test_q;
		res         = '0;
		case (rd_data.op)
			apci_pkg::OP_RX_I: begin
				if (rd_data.ns != rcv_cnt_q) begin
					res.status = apci_pkg::ST_SEQ_FAIL;
				end else begin
					rcv_nxt        = rcv_cnt_q + 15'd1;
					unack_nxt      = unack_inc;
					res.asdu_ready = 1'b1;
					res.asdu_size  = rd_data.asdu_size;
					if (unack_inc >= ack_window_q) begin
						res.tx_kind     = apci_pkg::TX_S;
						res.tx_apdu_len = apci_pkg::LEN_SU;
						res.tx_control  = {rcv_nxt, 1'b0, 16'h0001};
						unack_nxt       = '0;
					end
				end
			end
			apci_pkg::OP_RX_START:   started_nxt = 1'b1;
			apci_pkg::OP_RX_STOP:    res.status = apci_pkg::ST_STOPPED;
			apci_pkg::OP_RX_TESTACT: begin
				res.tx_kind     = apci_pkg::TX_U;
				res.tx_apdu_len = apci_pkg::LEN_SU;
				res.tx_control  = {24'd0, apci_pkg::U_TESTFR_CON};
			end
			apci_pkg::OP_RX_TESTCON: test_nxt = 1'b0;
			apci_pkg::OP_INTERR: begin
				res.tx_kind           = apci_pkg::TX_I;
				res.tx_apdu_len       = apci_pkg::LEN_I;
				res.tx_control        = {rcv_cnt_q, 1'b0, snd_cnt_q, 1'b0};
				res.tx_common_address = rd_data.addr;
				snd_nxt               = snd_cnt_q + 15'd1;
			end
			apci_pkg::OP_SEND_U, apci_pkg::OP_SEND_TESTACT: begin
				res.tx_kind     = apci_pkg::TX_U;
				res.tx_apdu_len = apci_pkg::LEN_SU;
				res.tx_control  = {24'd0, rd_data.octet};
				if (rd_data.op == apci_pkg::OP_SEND_TESTACT) begin
					test_nxt = 1'b1;
				end
			end
			apci_pkg::OP_SEND_S: begin
				res.tx_kind     = apci_pkg::TX_S;
				res.tx_apdu_len = apci_pkg::LEN_SU;
				res.tx_control  = {rcv_cnt_q, 1'b0, 16'h0001};
				unack_nxt       = '0;
			end
			default: res = '0;
		endcase
		res.started      = started_nxt;
		res.test_pending = test_nxt;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_window_q <= apci_pkg::ACK_WINDOW_RESET;
			rcv_cnt_q    <= '0;
			snd_cnt_q    <= '0;
			unack_q      <= '0;
			started_q    <= 1'b0;
			test_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				ack_window_q <= cfg_wdata;
			end
			if (pop) begin
				rcv_cnt_q <= rcv_nxt;
				snd_cnt_q <= snd_nxt;
				unack_q   <= unack_nxt;
				started_q <= started_nxt;
				test_q    <= test_nxt;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/apci_link_sequencer.sv
// Master-side APCI control layer of a telecontrol link.
// Input channel (in_valid, in_stall, in_data): one transaction per request,
// either a received frame header or a request to send an interrogation,
// a U frame or an S frame. Output channel (out_valid, out_stall, out_data):
// exactly one result transaction per input transaction, in order.
// Configuration: cfg_we with cfg_wdata writes the acknowledge window; write
// it only while no transaction is in flight.
// A request is held in a decode queue entry, and its result is then
// registered in the sequence/counter stage before it is offered.
// Throughput: one transaction per cycle while out_stall is low, set by the
// counter update in the back stage.
// A two-entry queue separates decode from execution; a stalled output
// holds its result and lets the queue fill, after which in_stall rises.
// Reset clears all counters, session flags and the queue, and sets the
// window to 8.
`default_nettype none

module apci_link_sequencer (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire apci_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output apci_pkg::out_t      out_data,
	input  wire                 cfg_we,
	input  wire [14:0]          cfg_wdata
);

	apci_pkg::item_t item;
	apci_pkg::item_t rd_data;
	logic            full;
	logic            push;
	logic            pop;
	logic            rd_valid;

	assign in_stall = full;
	assign push     = in_valid && !full;

	apci_front u_front (
		.in_data (in_data),
		.item    (item)
	);

	apci_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (item),
		.full      (full),
		.pop       (pop),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data)
	);

	apci_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rd_valid  (rd_valid),
		.rd_data   (rd_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
